### src/selective_repeat_reorder_buffer_unit_defines.svh
// Assertion macros for the reorder buffer unit.
// No dependencies; included by files that carry concurrent checks.
`ifndef SELECTIVE_REPEAT_REORDER_BUFFER_UNIT_DEFINES_SVH
`define SELECTIVE_REPEAT_REORDER_BUFFER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRRB_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/srrb_pkg.sv
// Shared widths, codes and reset constants for the reorder buffer unit.
// No dependencies; used by the top level, srrb_modulo and both testbench files.
package srrb_pkg;

	localparam int FUNC_W    = 2;
	localparam int SEQ_W     = 31;
	localparam int SIZE_W    = 10;
	localparam int WIDX_W    = 6;
	localparam int WORD_W    = 64;
	localparam int CFG_W     = 7;
	localparam int HIGHEST_W = 32;

	localparam int DEF_MAX_WINDOW       = 64;
	localparam int DEF_WORDS_PER_PACKET = 64;

	localparam logic [CFG_W-1:0]            WINDOW_RESET  = 7'd64;
	localparam logic signed [HIGHEST_W-1:0] HIGHEST_RESET = -32'sd1;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_STORE = 2'd0,
		FUNC_FETCH = 2'd1,
		FUNC_QUERY = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_META,
		ST_CHECK,
		ST_FETCH
	} state_t;

endpackage

### src/srrb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module srrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### src/srrb_modulo.sv
// Bit-serial remainder unit: sequence number modulo the active window size.
// Depends on srrb_pkg for the sequence width.
module srrb_modulo #(
	parameter int MAX_WINDOW = srrb_pkg::DEF_MAX_WINDOW
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             start,
	input  logic [srrb_pkg::SEQ_W-1:0]                       dividend,
	input  logic [$clog2(MAX_WINDOW + 1)-1:0]                divisor,
	output logic                                             done,
	output logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] remainder
);

	localparam int AW    = $clog2(MAX_WINDOW + 1);
	localparam int SW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_W = $clog2(srrb_pkg::SEQ_W);

	logic [srrb_pkg::SEQ_W-1:0] dvd_q;
	logic [AW-1:0]              rem_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       run_q;
	logic                       done_q;
	logic [AW:0]                rem_shift;
	logic [AW-1:0]              rem_next;

	// one restoring step: bring in the next dividend bit, subtract if it fits
	always_comb begin
		rem_shift = {rem_q, dvd_q[srrb_pkg::SEQ_W-1]};
		if (rem_shift >= {1'b0, divisor}) begin
			rem_next = AW'(rem_shift - {1'b0, divisor});
		end else begin
			rem_next = rem_shift[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(srrb_pkg::SEQ_W - 1);
		end else if (run_q) begin
			if (cnt_q == '0) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[srrb_pkg::SEQ_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign remainder = SW'(rem_q);

endmodule

### src/selective_repeat_reorder_buffer_unit.sv
// Top level of the selective-repeat receive reorder buffer.
// Depends on srrb_pkg, srrb_ram, srrb_modulo and the assertion macro header.
//
// Usage:
//   Requests enter on start/func/seq_num/pkt_bytes/word_index/data_word and
//   are taken at a clock edge with start high and busy low. A store writes one
//   payload word plus the slot header; a fetch streams the next in-order packet
//   one word per cycle; a query reports whether that packet has arrived.
//   Results leave on out_valid with found/out_size/out_word/last/highest_seen,
//   one cycle each; the receiver cannot stall, so nothing is ever held back.
//   The window register is written over cfg_valid/cfg_ready/cfg_data while the
//   block is idle (cfg_ready is high exactly then).
// Timing:
//   The slot index comes from a bit-serial remainder unit that retires one of
//   the 31 sequence bits per cycle. A store answers once the remainder is done;
//   a query or fetch first reads the slot header, and a fetch then gives its
//   words back to back. busy covers the whole run, so one request is in flight
//   at a time.
// Reset:
//   arst_n clears all slot valid bits, sets the expected number to zero, the
//   highest seen number to -1 and the window to its full size. No clearing pass
//   is needed: payload and header memories are only read behind a valid bit.
`include "selective_repeat_reorder_buffer_unit_defines.svh"

module selective_repeat_reorder_buffer_unit #(
	parameter int MAX_WINDOW       = srrb_pkg::DEF_MAX_WINDOW,
	parameter int WORDS_PER_PACKET = srrb_pkg::DEF_WORDS_PER_PACKET
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// request channel
	input  logic                                  start,
	output logic                                  busy,
	input  logic [srrb_pkg::FUNC_W-1:0]           func,
	input  logic [srrb_pkg::SEQ_W-1:0]            seq_num,
	input  logic [srrb_pkg::SIZE_W-1:0]           pkt_bytes,
	input  logic [srrb_pkg::WIDX_W-1:0]           word_index,
	input  logic [srrb_pkg::WORD_W-1:0]           data_word,
	// result channel
	output logic                                  out_valid,
	output logic                                  found,
	output logic [srrb_pkg::SIZE_W-1:0]           out_size,
	output logic [srrb_pkg::WORD_W-1:0]           out_word,
	output logic                                  last,
	output logic signed [srrb_pkg::HIGHEST_W-1:0] highest_seen,
	// configuration channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [srrb_pkg::CFG_W-1:0]            cfg_data
);

	localparam int AW        = $clog2(MAX_WINDOW + 1);
	localparam int SW        = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int WW        = (WORDS_PER_PACKET > 1) ? $clog2(WORDS_PER_PACKET) : 1;
	localparam int CNT_W     = $clog2(WORDS_PER_PACKET + 1);
	localparam int MAX_BYTES = WORDS_PER_PACKET * 8;
	localparam int META_W    = srrb_pkg::SEQ_W + srrb_pkg::SIZE_W;
	localparam int NW_W      = srrb_pkg::SIZE_W - 2;

	srrb_pkg::state_t state_q, state_d;

	// configuration and architectural state
	logic [srrb_pkg::CFG_W-1:0]            window_q;
	logic [MAX_WINDOW-1:0]                 slot_valid_q;
	logic [srrb_pkg::SEQ_W-1:0]            expected_q;
	logic signed [srrb_pkg::HIGHEST_W-1:0] highest_q;

	// request held for the run
	logic [srrb_pkg::FUNC_W-1:0]  func_q;
	logic [srrb_pkg::SEQ_W-1:0]   seq_q;
	logic [srrb_pkg::SIZE_W-1:0]  size_q;
	logic [srrb_pkg::WIDX_W-1:0]  widx_q;
	logic [srrb_pkg::WORD_W-1:0]  word_q;
	logic [SW-1:0]                slot_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [CNT_W-1:0]             nwords_q;
	logic [srrb_pkg::SIZE_W-1:0]  fsize_q;

	// result registers
	logic                         out_valid_q;
	logic                         found_q;
	logic [srrb_pkg::SIZE_W-1:0]  out_size_q;
	logic                         last_q;
	logic                         word_sel_q;

	// control from the sequencer
	logic                         accept;
	logic                         div_start;
	logic                         div_done;
	logic [SW-1:0]                div_rem;
	logic [AW-1:0]                active_slots;
	logic [srrb_pkg::SEQ_W-1:0]   div_dividend;
	logic                         meta_we;
	logic                         pay_we;
	logic                         set_valid;
	logic                         clr_valid;
	logic                         load_fetch;
	logic                         adv_fetch;
	logic                         emit;
	logic                         emit_found;
	logic                         emit_last;
	logic                         emit_word;
	logic [srrb_pkg::SIZE_W-1:0]  emit_size;
	logic                         hit;
	logic                         widx_ok;
	logic                         fetch_last;
	logic [srrb_pkg::SIZE_W-1:0]  size_sat;
	logic [NW_W-1:0]              nwords_calc;

	// memories
	logic [META_W-1:0]            meta_rdata;
	logic [srrb_pkg::SEQ_W-1:0]   meta_seq;
	logic [srrb_pkg::SIZE_W-1:0]  meta_size;
	logic [srrb_pkg::WORD_W-1:0]  pay_rdata;

	assign accept    = start && !busy;
	assign busy      = (state_q != srrb_pkg::ST_IDLE);
	assign cfg_ready = (state_q == srrb_pkg::ST_IDLE);

	// clamp the configured window: zero acts as one, above the maximum saturates
	always_comb begin
		if (window_q == '0) begin
			active_slots = AW'(1);
		end else if (32'(window_q) > MAX_WINDOW) begin
			active_slots = AW'(MAX_WINDOW);
		end else begin
			active_slots = AW'(window_q);
		end
	end

	// a store indexes by its own number, fetch and query by the expected one
	assign div_dividend = (func == srrb_pkg::FUNC_STORE) ? seq_num : expected_q;

	assign size_sat = (32'(pkt_bytes) > MAX_BYTES) ? srrb_pkg::SIZE_W'(MAX_BYTES) : pkt_bytes;

	assign meta_seq    = meta_rdata[META_W-1:srrb_pkg::SIZE_W];
	assign meta_size   = meta_rdata[srrb_pkg::SIZE_W-1:0];
	assign hit         = slot_valid_q[slot_q] && (meta_seq == expected_q);
	assign nwords_calc = NW_W'((11'(meta_size) + 11'd7) >> 3);
	assign widx_ok     = (32'(widx_q) < WORDS_PER_PACKET);
	assign fetch_last  = ((cnt_q + CNT_W'(1)) == nwords_q);

	srrb_modulo #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_modulo (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (active_slots),
		.done     (div_done),
		.remainder(div_rem)
	);

	// slot header: sequence number and byte length
	srrb_ram #(
		.WIDTH(META_W),
		.DEPTH(2 ** SW)
	) u_meta_ram (
		.clk  (clk),
		.we   (meta_we),
		.waddr(div_rem),
		.wdata({seq_q, size_q}),
		.raddr(slot_q),
		.rdata(meta_rdata)
	);

	// payload words, one row of words per slot
	srrb_ram #(
		.WIDTH(srrb_pkg::WORD_W),
		.DEPTH(2 ** (SW + WW))
	) u_payload_ram (
		.clk  (clk),
		.we   (pay_we),
		.waddr({div_rem, widx_q[WW-1:0]}),
		.wdata(word_q),
		.raddr({slot_q, cnt_q[WW-1:0]}),
		.rdata(pay_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srrb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state and per-cycle controls
	always_comb begin
		state_d    = state_q;
		div_start  = 1'b0;
		meta_we    = 1'b0;
		pay_we     = 1'b0;
		set_valid  = 1'b0;
		clr_valid  = 1'b0;
		load_fetch = 1'b0;
		adv_fetch  = 1'b0;
		emit       = 1'b0;
		emit_found = 1'b0;
		emit_last  = 1'b1;
		emit_word  = 1'b0;
		emit_size  = '0;
		case (state_q)
			srrb_pkg::ST_IDLE: begin
				// an unused selector is taken and dropped with no result
				if (accept && (func inside {srrb_pkg::FUNC_STORE, srrb_pkg::FUNC_FETCH,
						srrb_pkg::FUNC_QUERY})) begin
					div_start = 1'b1;
					state_d   = srrb_pkg::ST_MOD;
				end
			end
			srrb_pkg::ST_MOD: begin
				if (div_done) begin
					if (func_q == srrb_pkg::FUNC_STORE) begin
						meta_we   = 1'b1;
						pay_we    = widx_ok;
						set_valid = 1'b1;
						emit      = 1'b1;
						state_d   = srrb_pkg::ST_IDLE;
					end else begin
						state_d = srrb_pkg::ST_META;
					end
				end
			end
			srrb_pkg::ST_META: begin
				// header read is in flight
				state_d = srrb_pkg::ST_CHECK;
			end
			srrb_pkg::ST_CHECK: begin
				if (func_q == srrb_pkg::FUNC_FETCH && hit) begin
					clr_valid = 1'b1;
					if (nwords_calc == '0) begin
						emit       = 1'b1;
						emit_found = 1'b1;
						emit_size  = meta_size;
						state_d    = srrb_pkg::ST_IDLE;
					end else begin
						load_fetch = 1'b1;
						state_d    = srrb_pkg::ST_FETCH;
					end
				end else begin
					emit       = 1'b1;
					emit_found = (func_q == srrb_pkg::FUNC_QUERY) && hit;
					state_d    = srrb_pkg::ST_IDLE;
				end
			end
			srrb_pkg::ST_FETCH: begin
				emit       = 1'b1;
				emit_found = 1'b1;
				emit_size  = fsize_q;
				emit_word  = 1'b1;
				emit_last  = fetch_last;
				adv_fetch  = 1'b1;
				if (fetch_last) begin
					state_d = srrb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = srrb_pkg::ST_IDLE;
			end
		endcase
	end

	// architectural state: window, valid bits, expected and highest numbers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q     <= srrb_pkg::WINDOW_RESET;
			slot_valid_q <= '0;
			expected_q   <= '0;
			highest_q    <= srrb_pkg::HIGHEST_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				window_q <= cfg_data;
			end
			if (set_valid) begin
				slot_valid_q[div_rem] <= 1'b1;
				if ($signed({1'b0, seq_q}) > highest_q) begin
					highest_q <= $signed({1'b0, seq_q});
				end
			end
			if (clr_valid) begin
				slot_valid_q[slot_q] <= 1'b0;
				expected_q           <= expected_q + srrb_pkg::SEQ_W'(1);
			end
		end
	end

	// request payload and run counters
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			seq_q  <= seq_num;
			size_q <= size_sat;
			widx_q <= word_index;
			word_q <= data_word;
		end
		if (div_done) begin
			slot_q <= div_rem;
		end
		if (load_fetch) begin
			cnt_q    <= '0;
			nwords_q <= CNT_W'(nwords_calc);
			fsize_q  <= meta_size;
		end else if (adv_fetch) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// result strobe; the payload word comes straight off the RAM's read register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			found_q    <= emit_found;
			out_size_q <= emit_size;
			last_q     <= emit_last;
			word_sel_q <= emit_word;
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign out_size     = out_size_q;
	assign last         = last_q;
	assign out_word     = word_sel_q ? pay_rdata : '0;
	assign highest_seen = highest_q;

	// a fetch streams its words without gaps
	`SRRB_ASSERT_NEXT(a_fetch_stream, clk, arst_n, out_valid && !last, out_valid, "fetch run broke")
	// a new request never overlaps a pending result
	`SRRB_ASSERT_NEXT(a_accept_quiet, clk, arst_n, accept, !out_valid, "result right after accept")
	// a result with found low carries no size and no word
	`SRRB_ASSERT_SAME(a_miss_empty, clk, arst_n, out_valid && !found, out_size == '0 && out_word == '0, "miss result not empty")

endmodule

### tb/srrb_result_checker.sv
// Result checker for the selective-repeat reorder buffer unit.
// Depends on srrb_pkg; watches the request, result and window channels.
module srrb_result_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic                                  busy,
	input  logic [srrb_pkg::FUNC_W-1:0]           func,
	input  logic [srrb_pkg::SEQ_W-1:0]            seq_num,
	input  logic [srrb_pkg::SIZE_W-1:0]           pkt_bytes,
	input  logic [srrb_pkg::WIDX_W-1:0]           word_index,
	input  logic [srrb_pkg::WORD_W-1:0]           data_word,
	input  logic                                  out_valid,
	input  logic                                  found,
	input  logic [srrb_pkg::SIZE_W-1:0]           out_size,
	input  logic [srrb_pkg::WORD_W-1:0]           out_word,
	input  logic                                  last,
	input  logic signed [srrb_pkg::HIGHEST_W-1:0] highest_seen,
	input  logic                                  cfg_valid,
	input  logic                                  cfg_ready,
	input  logic [srrb_pkg::CFG_W-1:0]            cfg_data,
	output int                                    fail_count,
	output int                                    pending
);

	localparam int SLOTS     = srrb_pkg::DEF_MAX_WINDOW;
	localparam int WORDS     = srrb_pkg::DEF_WORDS_PER_PACKET;
	localparam int MAX_BYTES = WORDS * 8;
	localparam int SHOWN     = 10;

	typedef struct packed {
		logic                                  found;
		logic [srrb_pkg::SIZE_W-1:0]           size;
		logic [srrb_pkg::WORD_W-1:0]           word;
		logic                                  last;
		logic signed [srrb_pkg::HIGHEST_W-1:0] highest;
	} packet_beat_t;

	logic                                  slot_live [SLOTS];
	logic [srrb_pkg::SEQ_W-1:0]            slot_seq  [SLOTS];
	logic [srrb_pkg::SIZE_W-1:0]           slot_len  [SLOTS];
	logic [srrb_pkg::WORD_W-1:0]           payload   [SLOTS][WORDS];
	logic [srrb_pkg::SEQ_W-1:0]            next_seq;
	logic signed [srrb_pkg::HIGHEST_W-1:0] top_seq;
	logic [srrb_pkg::CFG_W-1:0]            window_reg;
	packet_beat_t                          beats_due [$];
	int                                    errors = 0;

	function automatic int unsigned active_slots();
		if (window_reg == '0)
			return 1;
		if (window_reg > SLOTS)
			return SLOTS;
		return 32'(window_reg);
	endfunction

	function automatic string beat_text(packet_beat_t b);
		return $sformatf("found=%0b size=%0d word=%h last=%0b highest=%0d",
			b.found, b.size, b.word, b.last, $signed(b.highest));
	endfunction

	function automatic void push_beat(logic f, logic [srrb_pkg::SIZE_W-1:0] sz,
		logic [srrb_pkg::WORD_W-1:0] w, logic l);
		packet_beat_t b;
		b.found   = f;
		b.size    = sz;
		b.word    = w;
		b.last    = l;
		b.highest = top_seq;
		beats_due.push_back(b);
	endfunction

	task automatic predict_request(input logic [srrb_pkg::FUNC_W-1:0] f,
		input logic [srrb_pkg::SEQ_W-1:0] s, input logic [srrb_pkg::SIZE_W-1:0] len,
		input logic [srrb_pkg::WIDX_W-1:0] idx, input logic [srrb_pkg::WORD_W-1:0] w);
		int unsigned slot;
		int          beats;
		logic        hit;
		if (f == srrb_pkg::FUNC_STORE) begin
			slot = s % active_slots();
			slot_seq[slot]  = s;
			slot_len[slot]  = (len > MAX_BYTES) ? srrb_pkg::SIZE_W'(MAX_BYTES) : len;
			slot_live[slot] = 1'b1;
			payload[slot][idx] = w;
			if ($signed({1'b0, s}) > top_seq)
				top_seq = $signed({1'b0, s});
			push_beat(1'b0, '0, '0, 1'b1);
		end else if (f == srrb_pkg::FUNC_FETCH || f == srrb_pkg::FUNC_QUERY) begin
			slot = next_seq % active_slots();
			hit  = slot_live[slot] && slot_seq[slot] == next_seq;
			if (f == srrb_pkg::FUNC_QUERY || !hit) begin
				push_beat(hit && f == srrb_pkg::FUNC_QUERY, '0, '0, 1'b1);
			end else begin
				beats = (int'(slot_len[slot]) + 7) / 8;
				if (beats > WORDS)
					beats = WORDS;
				slot_live[slot] = 1'b0;
				next_seq = next_seq + 1'b1;
				// an empty packet still answers with one beat
				if (beats == 0)
					push_beat(1'b1, slot_len[slot], '0, 1'b1);
				for (int i = 0; i < beats; i++)
					push_beat(1'b1, slot_len[slot], payload[slot][i], i == beats - 1);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		packet_beat_t want;
		packet_beat_t got;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++)
				slot_live[i] = 1'b0;
			next_seq   = '0;
			top_seq    = srrb_pkg::HIGHEST_RESET;
			window_reg = srrb_pkg::WINDOW_RESET;
			beats_due.delete();
			pending <= 0;
		end else begin
			// compare before predicting so a fresh request never meets an older beat
			if (out_valid) begin
				got.found   = found;
				got.size    = out_size;
				got.word    = out_word;
				got.last    = last;
				got.highest = highest_seen;
				if (beats_due.size() == 0) begin
					errors++;
					if (errors <= SHOWN)
						$display("unexpected result: %s", beat_text(got));
				end else begin
					want = beats_due.pop_front();
					if (got.found !== want.found || got.size !== want.size ||
						got.word !== want.word || got.last !== want.last ||
						got.highest !== want.highest) begin
						errors++;
						if (errors <= SHOWN)
							$display("result mismatch: expected %s, got %s",
								beat_text(want), beat_text(got));
					end
				end
			end
			if (cfg_valid && cfg_ready)
				window_reg = cfg_data;
			if (start && !busy)
				predict_request(func, seq_num, pkt_bytes, word_index, data_word);
			pending <= beats_due.size();
		end
		fail_count <= errors;
	end

endmodule

### tb/selective_repeat_reorder_buffer_unit_test.sv
// Stimulus and verdict for the selective-repeat reorder buffer unit.
// Depends on srrb_pkg, the unit itself and srrb_result_checker.
module selective_repeat_reorder_buffer_unit_test;

	localparam int SLOTS        = srrb_pkg::DEF_MAX_WINDOW;
	localparam int WORDS        = srrb_pkg::DEF_WORDS_PER_PACKET;
	localparam int MAX_BYTES    = WORDS * 8;
	localparam int CYCLE_LIMIT  = 600000;
	// longest run: modulo pass plus a full 64-word fetch, with margin
	localparam int SETTLE       = 120;
	localparam int PHASE_ITEMS  = 28;
	localparam logic [srrb_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	logic                                  clk        = 1'b0;
	logic                                  arst_n     = 1'b0;
	logic                                  start      = 1'b0;
	logic [srrb_pkg::FUNC_W-1:0]           func       = '0;
	logic [srrb_pkg::SEQ_W-1:0]            seq_num    = '0;
	logic [srrb_pkg::SIZE_W-1:0]           pkt_bytes  = '0;
	logic [srrb_pkg::WIDX_W-1:0]           word_index = '0;
	logic [srrb_pkg::WORD_W-1:0]           data_word  = '0;
	logic                                  cfg_valid  = 1'b0;
	logic [srrb_pkg::CFG_W-1:0]            cfg_data   = '0;
	logic                                  busy;
	logic                                  out_valid;
	logic                                  found;
	logic [srrb_pkg::SIZE_W-1:0]           out_size;
	logic [srrb_pkg::WORD_W-1:0]           out_word;
	logic                                  last;
	logic signed [srrb_pkg::HIGHEST_W-1:0] highest_seen;
	logic                                  cfg_ready;
	int                                    fail_count;
	int                                    pending;

	// Legality tracking for stimulus only: which slot headers are live and
	// which payload words were ever written, so that no fetch reads a word
	// that was never stored.
	bit                          hdr_live   [SLOTS];
	logic [srrb_pkg::SEQ_W-1:0]  hdr_seq    [SLOTS];
	logic [srrb_pkg::SIZE_W-1:0] hdr_len    [SLOTS];
	bit                          word_known [SLOTS][WORDS];
	logic [srrb_pkg::SEQ_W-1:0]  next_due   = '0;
	int                          window_eff = SLOTS;
	int                          sender_idle_pct = 0;
	int                          item_count = 0;
	int                          cycles = 0;

	always #5 clk = ~clk;

	selective_repeat_reorder_buffer_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.seq_num      (seq_num),
		.pkt_bytes    (pkt_bytes),
		.word_index   (word_index),
		.data_word    (data_word),
		.out_valid    (out_valid),
		.found        (found),
		.out_size     (out_size),
		.out_word     (out_word),
		.last         (last),
		.highest_seen (highest_seen),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	srrb_result_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.seq_num      (seq_num),
		.pkt_bytes    (pkt_bytes),
		.word_index   (word_index),
		.data_word    (data_word),
		.out_valid    (out_valid),
		.found        (found),
		.out_size     (out_size),
		.out_word     (out_word),
		.last         (last),
		.highest_seen (highest_seen),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// Hard stop: a hang or a result that never arrives ends here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Drive one request and hold it until the block takes it. start stays
	// high afterwards so back-to-back requests never toggle it within a step;
	// callers that pause drop it themselves.
	task automatic send_request(input logic [srrb_pkg::FUNC_W-1:0] f,
		input logic [srrb_pkg::SEQ_W-1:0] s, input logic [srrb_pkg::SIZE_W-1:0] len,
		input logic [srrb_pkg::WIDX_W-1:0] idx, input logic [srrb_pkg::WORD_W-1:0] w);
		int slot;
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		func       <= f;
		seq_num    <= s;
		pkt_bytes  <= len;
		word_index <= idx;
		data_word  <= w;
		do @(posedge clk); while (busy);
		// request accepted at this edge; mirror its effect on the slot headers
		if (f == srrb_pkg::FUNC_STORE) begin
			slot = s % window_eff;
			hdr_live[slot] = 1'b1;
			hdr_seq[slot]  = s;
			hdr_len[slot]  = (len > MAX_BYTES) ? srrb_pkg::SIZE_W'(MAX_BYTES) : len;
			word_known[slot][idx] = 1'b1;
		end else if (f == srrb_pkg::FUNC_FETCH) begin
			slot = next_due % window_eff;
			if (hdr_live[slot] && hdr_seq[slot] == next_due) begin
				hdr_live[slot] = 1'b0;
				next_due = next_due + 1'b1;
			end
		end
		if (f != FUNC_UNUSED)
			item_count++;
	endtask

	// Fetch, query or unused selector with random don't-care fields.
	task automatic send_control(input logic [srrb_pkg::FUNC_W-1:0] f);
		send_request(f, srrb_pkg::SEQ_W'($urandom), srrb_pkg::SIZE_W'($urandom),
			srrb_pkg::WIDX_W'($urandom), {$urandom, $urandom});
	endtask

	// Fetch the next in-order packet; first fill any payload word it would
	// read that was never written.
	task automatic fetch_in_order();
		int slot;
		int beats;
		slot = next_due % window_eff;
		if (hdr_live[slot] && hdr_seq[slot] == next_due) begin
			beats = (int'(hdr_len[slot]) + 7) / 8;
			for (int i = 0; i < beats; i++)
				if (!word_known[slot][i])
					send_request(srrb_pkg::FUNC_STORE, next_due, hdr_len[slot],
						srrb_pkg::WIDX_W'(i), {$urandom, $urandom});
		end
		send_control(srrb_pkg::FUNC_FETCH);
	endtask

	// Store a whole packet word by word in rotated order; now and then drop
	// the final word to leave a broken packet behind.
	task automatic send_packet(input logic [srrb_pkg::SEQ_W-1:0] s,
		input logic [srrb_pkg::SIZE_W-1:0] len);
		int  beats;
		int  offset;
		bit  broken;
		beats  = ((len > MAX_BYTES ? MAX_BYTES : int'(len)) + 7) / 8;
		if (beats == 0)
			beats = 1;
		offset = $urandom_range(beats - 1);
		broken = beats > 1 && $urandom_range(7) == 0;
		for (int k = 0; k < beats; k++)
			if (!(broken && k == beats - 1))
				send_request(srrb_pkg::FUNC_STORE, s, len,
					srrb_pkg::WIDX_W'((offset + k) % beats), {$urandom, $urandom});
	endtask

	// Mostly the expected number or a little ahead of it, sometimes anywhere.
	function automatic logic [srrb_pkg::SEQ_W-1:0] pick_seq();
		int r;
		r = $urandom_range(9);
		if (r < 4)
			return next_due;
		if (r < 8)
			return next_due + srrb_pkg::SEQ_W'($urandom_range(window_eff + 2, 1));
		return srrb_pkg::SEQ_W'($urandom);
	endfunction

	// Small packets dominate; a few reach or pass the saturation length.
	function automatic logic [srrb_pkg::SIZE_W-1:0] pick_size();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return srrb_pkg::SIZE_W'($urandom_range(64));
		if (r < 96)
			return srrb_pkg::SIZE_W'($urandom_range(200, 65));
		return srrb_pkg::SIZE_W'($urandom_range(1023));
	endfunction

	// Write the window while the block is idle: drain results, let any
	// result-less request finish, then complete the handshake.
	task automatic set_window(input logic [srrb_pkg::CFG_W-1:0] v);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		window_eff = (v == '0) ? 1 : (v > SLOTS) ? SLOTS : int'(v);
	endtask

	initial begin
		logic [srrb_pkg::CFG_W-1:0] windows [6];
		int                         r;
		int                         goal;
		windows[0] = srrb_pkg::CFG_W'($urandom_range(63, 2));
		windows[1] = 7'd1;
		windows[2] = 7'd0;    // acts as a single slot
		windows[3] = 7'd127;  // clamps to the full window
		windows[4] = 7'd64;
		windows[5] = srrb_pkg::CFG_W'($urandom_range(126, 65));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		sender_idle_pct = 34;

		// Directed: empty buffer, ignored selector, in-order hit, empty packet,
		// extreme sequence number with an oversized length, a slot held by a
		// foreign sequence number, and an overwrite of that slot.
		send_control(srrb_pkg::FUNC_QUERY);
		send_control(srrb_pkg::FUNC_FETCH);
		send_request(FUNC_UNUSED, '1, '1, '1, '1);
		send_request(srrb_pkg::FUNC_STORE, 31'd0, 10'd16, 6'd0, '0);
		send_request(srrb_pkg::FUNC_STORE, 31'd0, 10'd16, 6'd1, '1);
		send_control(srrb_pkg::FUNC_QUERY);
		fetch_in_order();
		send_request(srrb_pkg::FUNC_STORE, 31'd1, 10'd0, 6'd63, {$urandom, $urandom});
		fetch_in_order();
		send_request(srrb_pkg::FUNC_STORE, '1, 10'd1023, 6'd63, '1);
		send_request(srrb_pkg::FUNC_STORE, 31'd66, 10'd8, 6'd0, 64'h0123_4567_89ab_cdef);
		send_control(srrb_pkg::FUNC_QUERY);
		send_control(srrb_pkg::FUNC_FETCH);
		send_request(srrb_pkg::FUNC_STORE, 31'd2, 10'd9, 6'd1, {$urandom, $urandom});
		send_request(srrb_pkg::FUNC_STORE, 31'd2, 10'd9, 6'd0, 64'hfedc_ba98_7654_3210);
		send_control(srrb_pkg::FUNC_QUERY);
		fetch_in_order();
		send_packet(31'd3, 10'd24);
		send_packet(31'd4, 10'd1);
		fetch_in_order();
		fetch_in_order();

		// Random phases, one per window setting; sender idling grows, then stops in the last two phases.
		for (int phase = 0; phase < 6; phase++) begin
			set_window(windows[phase]);
			sender_idle_pct = (phase < 2) ? 34 : (phase < 4) ? 46 : 0;
			goal = item_count + PHASE_ITEMS;
			while (item_count < goal) begin
				r = $urandom_range(99);
				if (r < 45)
					send_packet(pick_seq(), pick_size());
				else if (r < 72)
					fetch_in_order();
				else if (r < 86)
					send_control(srrb_pkg::FUNC_QUERY);
				else if (r < 95)
					send_request(srrb_pkg::FUNC_STORE, srrb_pkg::SEQ_W'($urandom),
						srrb_pkg::SIZE_W'($urandom), srrb_pkg::WIDX_W'($urandom),
						{$urandom, $urandom});
				else
					send_control(FUNC_UNUSED);
			end
		end

		// Drain: wait out the last results, then a full run length of quiet.
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### sim.f
+incdir+src
src/srrb_pkg.sv
src/srrb_ram.sv
src/srrb_modulo.sv
src/selective_repeat_reorder_buffer_unit.sv
tb/srrb_result_checker.sv
tb/selective_repeat_reorder_buffer_unit_test.sv
